FILE: rtl/utf8lc_pkg.sv
package utf8lc_pkg;

    // Bytes per beat and width of the saturating totals
    localparam int LANES       = 8;
    localparam int COUNT_BITS  = 48;

    // Bytes held back for lookahead between beats
    localparam int CARRY_DEPTH = 3;
    localparam int BUF_LEN     = LANES + CARRY_DEPTH;
    localparam int LEN_W       = $clog2(BUF_LEN + 1);
    localparam int FILL_W      = $clog2(CARRY_DEPTH + 1);

    // Byte field widths fixed by the interface
    localparam int DATA_W      = 64;
    localparam int BCNT_W      = 4;

    typedef logic [7:0] t_byte;

    // Per-beat result of the scan logic
    typedef struct packed {
        logic [LEN_W-1:0]                starts;
        logic [LEN_W-1:0]                newlines;
        logic [FILL_W-1:0]               fill;
        logic [CARRY_DEPTH-1:0][7:0]     pend;
    } t_scan;

endpackage

FILE: rtl/utf8lc_scan.sv
module utf8lc_scan
    import utf8lc_pkg::*;
(
    input  logic [CARRY_DEPTH-1:0][7:0] i_pend,
    input  logic [FILL_W-1:0]           i_fill,
    input  logic [DATA_W-1:0]           i_data_bytes,
    input  logic [BCNT_W-1:0]           i_byte_count,
    input  logic                        i_last,
    output t_scan                       o_scan
);

    localparam int EXT_LEN = BUF_LEN + CARRY_DEPTH;
    localparam int IDX_W   = $clog2(EXT_LEN);

    // Structural RFC 3629 start check; p1..p3 mark lookahead bytes present
    function automatic logic is_start(input t_byte b0, input t_byte b1,
                                      input t_byte b2, input t_byte b3,
                                      input logic p1, input logic p2,
                                      input logic p3);
        logic  c1, c2, c3;
        t_byte lo, hi;
        logic  ok;
        c1 = p1 && ((b1 & 8'hC0) == 8'h80);
        c2 = p2 && ((b2 & 8'hC0) == 8'h80);
        c3 = p3 && ((b3 & 8'hC0) == 8'h80);
        ok = 1'b0;
        if (b0 < 8'h80) begin
            ok = 1'b1;
        end else if (b0 >= 8'hC2 && b0 <= 8'hDF) begin
            ok = c1;
        end else if (b0 >= 8'hE0 && b0 <= 8'hEF) begin
            lo = (b0 == 8'hE0) ? 8'hA0 : 8'h80;
            hi = (b0 == 8'hED) ? 8'h9F : 8'hBF;
            ok = p1 && b1 >= lo && b1 <= hi && c2;
        end else if (b0 >= 8'hF0 && b0 <= 8'hF4) begin
            lo = (b0 == 8'hF0) ? 8'h90 : 8'h80;
            hi = (b0 == 8'hF4) ? 8'h8F : 8'hBF;
            ok = p1 && b1 >= lo && b1 <= hi && c2 && c3;
        end
        return ok;
    endfunction

    logic [LEN_W-1:0]   take;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   judged;
    t_byte              buf_x  [EXT_LEN];
    logic               pres_x [EXT_LEN];
    logic [BUF_LEN-1:0] start_vec;
    logic [BUF_LEN-1:0] nl_vec;
    logic [IDX_W-1:0]   sel    [CARRY_DEPTH];

    // Clamp the byte count to the lane count
    assign take = (i_byte_count > BCNT_W'(LANES)) ? LEN_W'(LANES) : LEN_W'(i_byte_count);
    assign len  = LEN_W'(i_fill) + take;

    // On the final beat every byte is judged, else up to three wait for lookahead
    assign judged = i_last ? len :
                    (len > LEN_W'(CARRY_DEPTH)) ? len - LEN_W'(CARRY_DEPTH) : '0;

    // Carried bytes first, then the new lanes; padding past the end is absent
    always_comb begin
        int idx;
        int idx_c;
        for (int j = 0; j < EXT_LEN; j++) begin
            idx   = j - int'(i_fill);
            idx_c = (idx < 0 || idx >= LANES) ? 0 : idx;
            buf_x[j]  = (idx >= 0 && idx < LANES) ? i_data_bytes[8*idx_c +: 8] : 8'h00;
            pres_x[j] = (j < int'(len));
        end
        for (int k = 0; k < CARRY_DEPTH; k++) begin
            if (k < int'(i_fill)) begin
                buf_x[k] = i_pend[k];
            end
        end
    end

    // Per-position start and newline flags, judged positions only
    always_comb begin
        for (int i = 0; i < BUF_LEN; i++) begin
            start_vec[i] = (i < int'(judged)) &&
                           is_start(buf_x[i], buf_x[i+1], buf_x[i+2], buf_x[i+3],
                                    pres_x[i+1], pres_x[i+2], pres_x[i+3]);
            nl_vec[i]    = (i < int'(judged)) && (buf_x[i] == 8'h0A);
        end
    end

    // Leftover bytes move to the front of the carry
    always_comb begin
        o_scan.starts   = LEN_W'($countones(start_vec));
        o_scan.newlines = LEN_W'($countones(nl_vec));
        o_scan.fill     = FILL_W'(len - judged);
        for (int k = 0; k < CARRY_DEPTH; k++) begin
            sel[k] = IDX_W'(judged) + IDX_W'(k);
            o_scan.pend[k] = (k < int'(o_scan.fill)) ? buf_x[sel[k]] : 8'h00;
        end
    end

endmodule

FILE: rtl/utf8_char_and_line_counter.sv
// A beat accepted into the input register is scanned there; on a last beat the totals
//   are loaded into the result register once it is free and stay until taken.
// Throughput: one beat per cycle; the input register, scan logic and result
//   register form a two-stage pipe that stalls only on a blocked result.
// Reset (synchronous, active low) empties both stages, the carry and totals.
module utf8_char_and_line_counter
    import utf8lc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [DATA_W-1:0]     i_data_bytes,
    input  logic [BCNT_W-1:0]     i_byte_count,
    input  logic                  i_last,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COUNT_BITS-1:0] o_char_count,
    output logic [COUNT_BITS-1:0] o_line_count
);

    logic                        r_s1_valid;
    logic [DATA_W-1:0]           r_s1_data;
    logic [BCNT_W-1:0]           r_s1_count;
    logic                        r_s1_last;
    logic [CARRY_DEPTH-1:0][7:0] r_pend;
    logic [FILL_W-1:0]           r_fill;
    logic [COUNT_BITS-1:0]       r_start_total;
    logic [COUNT_BITS-1:0]       r_line_total;
    logic                        r_out_valid;
    logic [COUNT_BITS-1:0]       r_out_char;
    logic [COUNT_BITS-1:0]       r_out_line;

    logic [COUNT_BITS:0]         start_sum;
    logic [COUNT_BITS:0]         line_sum;
    logic [COUNT_BITS-1:0]       n_start_total;
    logic [COUNT_BITS-1:0]       n_line_total;
    logic                        out_free;
    logic                        proc;
    t_scan                       scan;

    utf8lc_scan u_scan (
        .i_pend       (r_pend),
        .i_fill       (r_fill),
        .i_data_bytes (r_s1_data),
        .i_byte_count (r_s1_count),
        .i_last       (r_s1_last),
        .o_scan       (scan)
    );

    // Handshake: a staged beat moves on unless it is last and the result is blocked
    assign out_free   = !r_out_valid || i_out_ready;
    assign proc       = r_s1_valid && (!r_s1_last || out_free);
    assign o_in_ready = !r_s1_valid || proc;

    // Saturating totals: a carry out of the top bit pins the total at its max
    assign start_sum     = {1'b0, r_start_total} + (COUNT_BITS+1)'(scan.starts);
    assign line_sum      = {1'b0, r_line_total} + (COUNT_BITS+1)'(scan.newlines);
    assign n_start_total = start_sum[COUNT_BITS] ? '1 : start_sum[COUNT_BITS-1:0];
    assign n_line_total  = line_sum[COUNT_BITS] ? '1 : line_sum[COUNT_BITS-1:0];

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_s1_data  <= i_data_bytes;
            r_s1_count <= i_byte_count;
            r_s1_last  <= i_last;
        end
    end

    // Carry and totals; a last beat starts a fresh stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend        <= '0;
            r_fill        <= '0;
            r_start_total <= '0;
            r_line_total  <= '0;
        end else if (proc) begin
            if (r_s1_last) begin
                r_pend        <= '0;
                r_fill        <= '0;
                r_start_total <= '0;
                r_line_total  <= '0;
            end else begin
                r_pend        <= scan.pend;
                r_fill        <= scan.fill;
                r_start_total <= n_start_total;
                r_line_total  <= n_line_total;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (proc && r_s1_last) begin
            r_out_char <= n_start_total;
            r_out_line <= n_line_total;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_char_count = r_out_char;
    assign o_line_count = r_out_line;

    // Carry never holds more than the lookahead depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(CARRY_DEPTH))
        else $error("carry fill exceeds lookahead depth");

    // A last beat clears the stream state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_s1_last |=> r_fill == '0 && r_start_total == '0 && r_line_total == '0)
        else $error("stream state not cleared after last beat");

    // A result is only loaded into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_s1_last |-> out_free)
        else $error("pending result overwritten");

    // A stalled staged beat is kept
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !proc |=> r_s1_valid && $stable(r_s1_data) && $stable(r_s1_last))
        else $error("stalled input stage lost its beat");

endmodule

FILE: verif/utf8_char_and_line_counter_test.sv
`timescale 1ns / 1ps

module utf8_char_and_line_counter_test;
    import utf8lc_pkg::*;

    localparam int    CLK_PERIOD     = 12;
    localparam int    RESET_CYCLES   = 8;
    localparam int    RANDOM_BEATS   = 1800;
    localparam int    SETTLE_CYCLES  = 20;
    localparam int    HOLD_AT_RESULT = 40;
    localparam int    HOLD_CYCLES    = 300;
    localparam longint TIMEOUT_CYCLES = 200000;
    localparam t_byte NEWLINE        = 8'h0A;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct {
        logic [DATA_W-1:0] data;
        logic [BCNT_W-1:0] cnt;
        logic              last;
        bit                drain;   // hold until all totals have come back
    } t_beat;

    typedef struct {
        logic [COUNT_BITS-1:0] chars;
        logic [COUNT_BITS-1:0] lines;
    } t_totals;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_ready;
    logic [DATA_W-1:0]     i_data_bytes = '0;
    logic [BCNT_W-1:0]     i_byte_count = '0;
    logic                  i_last       = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready  = 1'b0;
    logic [COUNT_BITS-1:0] o_char_count;
    logic [COUNT_BITS-1:0] o_line_count;

    utf8_char_and_line_counter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_bytes (i_data_bytes),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_char_count (o_char_count),
        .o_line_count (o_line_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Stimulus and expected totals
    t_beat   pend_q[$];
    t_totals exp_totals_q[$];
    t_byte   sbytes[$];

    // Shadow of the counter state
    t_byte                 carry_q [CARRY_DEPTH];
    int                    carry_n   = 0;
    logic [COUNT_BITS-1:0] run_chars = '0;
    logic [COUNT_BITS-1:0] run_lines = '0;

    int     n_queued   = 0;
    int     n_taken    = 0;
    int     n_results  = 0;
    int     n_errors   = 0;
    longint sum_chars  = 0;
    longint sum_lines  = 0;

    t_beat cur_beat;
    int    send_gap   = 0;
    int    send_calm  = 0;
    int    recv_gap   = 0;
    int    recv_calm  = 0;
    int    hold_left  = 0;
    bit    hold_done  = 0;

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic bit cont_at(input t_byte w [BUF_LEN], input int n, input int j);
        if (j >= n)
            return 1'b0;
        return (w[j] & 8'hC0) == 8'h80;
    endfunction

    function automatic bit in_span(input t_byte w [BUF_LEN], input int n, input int j,
                                   input t_byte lo, input t_byte hi);
        if (j >= n)
            return 1'b0;
        return (w[j] >= lo) && (w[j] <= hi);
    endfunction

    // True when a well-formed sequence begins at position i of the window
    function automatic bit lead_ok(input t_byte w [BUF_LEN], input int n, input int i);
        t_byte b;
        t_byte lo;
        t_byte hi;
        b = w[i];
        if (b < 8'h80)
            return 1'b1;
        if (b >= 8'hC2 && b <= 8'hDF)
            return cont_at(w, n, i + 1);
        if (b >= 8'hE0 && b <= 8'hEF) begin
            lo = (b == 8'hE0) ? 8'hA0 : 8'h80;
            hi = (b == 8'hED) ? 8'h9F : 8'hBF;
            return in_span(w, n, i + 1, lo, hi) && cont_at(w, n, i + 2);
        end
        if (b >= 8'hF0 && b <= 8'hF4) begin
            lo = (b == 8'hF0) ? 8'h90 : 8'h80;
            hi = (b == 8'hF4) ? 8'h8F : 8'hBF;
            return in_span(w, n, i + 1, lo, hi) && cont_at(w, n, i + 2) &&
                   cont_at(w, n, i + 3);
        end
        return 1'b0;
    endfunction

    // Advance the shadow state by one accepted beat
    function automatic void scan_beat(input t_beat b);
        t_byte   win [BUF_LEN];
        int      n;
        int      take;
        int      judged;
        t_totals t;
        n = 0;
        take = (b.cnt > LANES) ? LANES : int'(b.cnt);
        for (int k = 0; k < carry_n; k++) begin
            win[n] = carry_q[k];
            n++;
        end
        for (int k = 0; k < take; k++) begin
            win[n] = b.data[8*k +: 8];
            n++;
        end
        // A byte is judged once three bytes of lookahead exist, or at stream end
        if (b.last)
            judged = n;
        else
            judged = (n > CARRY_DEPTH) ? n - CARRY_DEPTH : 0;
        for (int i = 0; i < judged; i++) begin
            if (lead_ok(win, n, i))
                run_chars = sat_inc(run_chars);
            if (win[i] == NEWLINE)
                run_lines = sat_inc(run_lines);
        end
        carry_n = n - judged;
        for (int k = 0; k < CARRY_DEPTH; k++)
            carry_q[k] = (k < carry_n) ? win[judged + k] : 8'h00;
        if (b.last) begin
            t.chars = run_chars;
            t.lines = run_lines;
            exp_totals_q.push_back(t);
            run_chars = '0;
            run_lines = '0;
            carry_n   = 0;
            for (int k = 0; k < CARRY_DEPTH; k++)
                carry_q[k] = 8'h00;
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus generation
    // ---------------------------------------------------------------
    function automatic int next_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(199) == 0) begin
            calm = $urandom_range(150, 40);
            return 0;
        end
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(80, 20);
    endfunction

    // Value in [lo, hi], biased toward the edges
    function automatic t_byte rand_in(input t_byte lo, input t_byte hi);
        int r;
        r = $urandom_range(3);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return t_byte'($urandom_range(hi, lo));
    endfunction

    // Append one character, or a malformed sequence with the given odds
    task automatic add_char(input int bad_pct);
        t_byte lead;
        t_byte lo;
        t_byte hi;
        int    kind;
        if ($urandom_range(99) < bad_pct) begin
            kind = $urandom_range(8);
            case (kind)
                0: begin
                    sbytes.push_back(rand_in(8'hC0, 8'hC1));
                    sbytes.push_back(rand_in(8'h80, 8'hBF));
                end
                1: sbytes.push_back(rand_in(8'hF5, 8'hFF));
                2: sbytes.push_back(rand_in(8'h80, 8'hBF));
                3: begin
                    // overlong three-byte form
                    sbytes.push_back(8'hE0);
                    sbytes.push_back(rand_in(8'h80, 8'h9F));
                    sbytes.push_back(rand_in(8'h80, 8'hBF));
                end
                4: begin
                    // surrogate range
                    sbytes.push_back(8'hED);
                    sbytes.push_back(rand_in(8'hA0, 8'hBF));
                    sbytes.push_back(rand_in(8'h80, 8'hBF));
                end
                5: begin
                    sbytes.push_back(8'hF0);
                    sbytes.push_back(rand_in(8'h80, 8'h8F));
                    sbytes.push_back(rand_in(8'h80, 8'hBF));
                    sbytes.push_back(rand_in(8'h80, 8'hBF));
                end
                6: begin
                    // above the code point limit
                    sbytes.push_back(8'hF4);
                    sbytes.push_back(rand_in(8'h90, 8'hBF));
                    sbytes.push_back(rand_in(8'h80, 8'hBF));
                    sbytes.push_back(rand_in(8'h80, 8'hBF));
                end
                7: begin
                    // truncated multibyte sequence
                    sbytes.push_back(rand_in(8'hE1, 8'hF3));
                    sbytes.push_back(rand_in(8'h80, 8'hBF));
                end
                default: sbytes.push_back(t_byte'($urandom_range(255)));
            endcase
        end else begin
            kind = $urandom_range(9);
            if (kind < 3) begin
                sbytes.push_back(t_byte'($urandom_range(8'h7F)));
            end else if (kind < 5) begin
                sbytes.push_back(NEWLINE);
            end else if (kind < 7) begin
                sbytes.push_back(rand_in(8'hC2, 8'hDF));
                sbytes.push_back(rand_in(8'h80, 8'hBF));
            end else if (kind < 9) begin
                lead = rand_in(8'hE0, 8'hEF);
                if ($urandom_range(2) == 0)
                    lead = ($urandom_range(1) == 0) ? 8'hE0 : 8'hED;
                lo = (lead == 8'hE0) ? 8'hA0 : 8'h80;
                hi = (lead == 8'hED) ? 8'h9F : 8'hBF;
                sbytes.push_back(lead);
                sbytes.push_back(rand_in(lo, hi));
                sbytes.push_back(rand_in(8'h80, 8'hBF));
            end else begin
                lead = rand_in(8'hF0, 8'hF4);
                lo = (lead == 8'hF0) ? 8'h90 : 8'h80;
                hi = (lead == 8'hF4) ? 8'h8F : 8'hBF;
                sbytes.push_back(lead);
                sbytes.push_back(rand_in(lo, hi));
                sbytes.push_back(rand_in(8'h80, 8'hBF));
                sbytes.push_back(rand_in(8'h80, 8'hBF));
            end
        end
    endtask

    task automatic push_beat(input logic [DATA_W-1:0] data, input int cnt, input bit last,
                             input bit drain);
        t_beat b;
        b.data  = data;
        b.cnt   = cnt[BCNT_W-1:0];
        b.last  = last;
        b.drain = drain;
        pend_q.push_back(b);
        n_queued++;
    endtask

    // Cut the byte buffer into beats; plain mode uses full beats but for a short final one
    task automatic flush_stream(input bit plain, input bit drain_first);
        logic [DATA_W-1:0] data;
        int                cnt;
        int                take;
        int                r;
        bit                first;
        bit                empty_tail;
        first = 1'b1;
        while (sbytes.size() > 0) begin
            data = {$urandom, $urandom};
            if (plain) begin
                cnt = LANES;
            end else begin
                r = $urandom_range(99);
                if (r < 4)
                    cnt = 0;
                else if (r < 8)
                    cnt = $urandom_range(15, LANES + 1);
                else
                    cnt = $urandom_range(LANES, 1);
            end
            take = (cnt > LANES) ? LANES : cnt;
            if (take > sbytes.size()) begin
                take = sbytes.size();
                cnt  = take;
            end
            for (int k = 0; k < take; k++)
                data[8*k +: 8] = sbytes.pop_front();
            empty_tail = !plain && sbytes.size() == 0 && $urandom_range(9) == 0;
            push_beat(data, cnt, sbytes.size() == 0 && !empty_tail, first && drain_first);
            if (empty_tail)
                push_beat({$urandom, $urandom}, 0, 1'b1, 1'b0);
            first = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------
    // Driver: input channel
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                scan_beat(cur_beat);
                n_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pend_q.size() > 0 &&
                             !(pend_q[0].drain && exp_totals_q.size() > 0)) begin
                    cur_beat = pend_q.pop_front();
                    i_in_valid   <= 1'b1;
                    i_data_bytes <= cur_beat.data;
                    i_byte_count <= cur_beat.cnt;
                    i_last       <= cur_beat.last;
                    send_gap = next_gap(send_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: result channel, with one long hold-off
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (exp_totals_q.size() == 0) begin
                    $error("unexpected result beat: char_count %0d line_count %0d",
                           o_char_count, o_line_count);
                    n_errors++;
                end else begin
                    t_totals t;
                    t = exp_totals_q.pop_front();
                    if (o_char_count !== t.chars) begin
                        $error("char_count mismatch: expected %0d, actual %0d",
                               t.chars, o_char_count);
                        n_errors++;
                    end
                    if (o_line_count !== t.lines) begin
                        $error("line_count mismatch: expected %0d, actual %0d",
                               t.lines, o_line_count);
                        n_errors++;
                    end
                    sum_chars += t.chars;
                    sum_lines += t.lines;
                end
                n_results++;
                recv_gap = next_gap(recv_calm);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && n_results >= HOLD_AT_RESULT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        int r;
        int n_chars;
        int bad_pct;
        bit first_random;

        // All-zero bytes, then all-ones bytes ending the stream
        push_beat({DATA_W{1'b0}}, LANES, 1'b0, 1'b0);
        push_beat({DATA_W{1'b1}}, LANES, 1'b1, 1'b0);
        // Zero byte count still ends the stream
        push_beat({$urandom, $urandom}, 0, 1'b1, 1'b0);
        // Byte count above the lane count is clamped
        push_beat({8{NEWLINE}}, 15, 1'b1, 1'b0);

        // Every lead class with its second-byte bounds, ending on a cut sequence
        sbytes = {8'hC2, 8'h80, 8'hC1, 8'h80, 8'hDF, 8'hBF,
                  8'hE0, 8'hA0, 8'h80, 8'hE0, 8'h9F, 8'h80,
                  8'hED, 8'h9F, 8'hBF, 8'hED, 8'hA0, 8'h80,
                  8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80,
                  8'hF0, 8'h8F, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                  8'hF4, 8'h90, 8'h80, 8'h80, 8'hF5, 8'h80, 8'h80, 8'h80,
                  8'h7F, NEWLINE, 8'hF0, 8'h90, 8'h80};
        flush_stream(1'b1, 1'b0);
        // Incomplete sequences right at the stream end
        push_beat({8'h00, $urandom, 24'h80E141}, 3, 1'b1, 1'b0);
        push_beat({8'h00, $urandom, 24'h0000C3} | 64'h0000_0000_0000_00C3, 1, 1'b1, 1'b0);

        // Random streams: mostly well-formed text, some broken, some raw noise
        first_random = 1'b1;
        while (n_queued < RANDOM_BEATS + 16) begin
            r = $urandom_range(99);
            bad_pct = (r < 75) ? 4 : (r < 90) ? 50 : 100;
            n_chars = ($urandom_range(9) == 0) ? $urandom_range(120, 30)
                                               : $urandom_range(30, 1);
            for (int k = 0; k < n_chars; k++)
                add_char(bad_pct);
            flush_stream(1'b0, first_random || $urandom_range(29) == 0);
            first_random = 1'b0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_taken < n_queued || exp_totals_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d beats in %0d streams with %0d mismatches.",
                 n_taken, n_results, n_errors);
        $display("Streams held %0d valid sequence starts and %0d newlines in total.",
                 sum_chars, sum_lines);
        if (n_errors == 0)
            $display("PASS utf8_char_and_line_counter");
        else
            $display("FAIL utf8_char_and_line_counter");
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timed out with %0d of %0d beats sent and %0d totals outstanding.",
                 n_taken, n_queued, exp_totals_q.size());
        $display("FAIL utf8_char_and_line_counter");
        $finish;
    end

endmodule

FILE: sim.f
rtl/utf8lc_pkg.sv
rtl/utf8lc_scan.sv
rtl/utf8_char_and_line_counter.sv
verif/utf8_char_and_line_counter_test.sv
